// File: src/sicrd_pkg.sv
// Package for the signed integer to radix digits unit.
// Holds shared widths, symbol codes, register indexes and the control structs.
// No dependencies.
package sicrd_pkg;

   localparam int SYMBOL_W     = 8;
   localparam int SYMBOL_WORDS = 4;
   localparam int SYMBOL_SLOTS = SYMBOL_WORDS * 8;
   localparam int RADIX_W      = 6;
   localparam int DIGIT_W      = 5;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 3;
   localparam int DIV_BITS     = 4;

   localparam logic [SYMBOL_W-1:0] MINUS_SYMBOL = 8'd45;
   localparam logic [SYMBOL_W-1:0] PLUS_SYMBOL  = 8'd43;
   localparam logic [SYMBOL_W-1:0] SPACE_SYMBOL = 8'd32;
   localparam logic [SYMBOL_W-1:0] TAB_SYMBOL   = 8'd9;
   localparam logic [SYMBOL_W-1:0] CR_SYMBOL    = 8'd13;

   localparam logic [CSR_INDEX_W-1:0] CSR_RADIX_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS_0    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS_1    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS_2    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS_3    = 3'd4;

   typedef logic [SYMBOL_WORDS-1:0][CSR_DATA_W-1:0] symbol_words_type;
   typedef logic [SYMBOL_SLOTS-1:0][SYMBOL_W-1:0] symbol_bank_type;

   typedef struct packed {
      logic load;
      logic chk_next;
      logic div_step;
      logic rd_issue;
      logic sel_digit;
      logic emit_err;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   typedef struct packed {
      logic len_bad;
      logic sym_bad;
      logic chk_last;
      logic div_done;
      logic negative;
      logic last_digit;
      logic out_free;
   } status_type;

   function automatic logic symbol_forbidden(input logic [SYMBOL_W-1:0] s);
      symbol_forbidden = (s == '0) || (s == SPACE_SYMBOL) || (s == PLUS_SYMBOL) ||
                         (s == MINUS_SYMBOL) || ((s >= TAB_SYMBOL) && (s <= CR_SYMBOL));
   endfunction

endpackage

// File: src/sicrd_ctrl.sv
// Controller state machine of the signed integer to radix digits unit.
// Sequences alphabet check, digit division and symbol output; uses sicrd_pkg.
module sicrd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sicrd_pkg::status_type st,
   output sicrd_pkg::cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_ERR   = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_SIGN  = 3'd4;
   localparam logic [2:0] ST_READ  = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (st.len_bad || st.sym_bad) begin
               state_in = ST_ERR;
            end else if (st.chk_last) begin
               state_in = ST_DIV;
            end else begin
               cmd.chk_next = 1'b1;
            end
         end
         ST_ERR: begin
            if (st.out_free) begin
               cmd.emit_err = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_done) begin
               state_in = st.negative ? ST_SIGN : ST_READ;
            end
         end
         ST_SIGN: begin
            if (st.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.sel_digit = 1'b1;
            if (st.out_free) begin
               cmd.emit_digit = 1'b1;
               state_in       = st.last_digit ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) && !st.div_done |=> (state_ff == ST_DIV))
      else $error("Division left before its last digit.");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_EMIT))
      else $error("Digit read not followed by output.");
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.emit_err, cmd.emit_sign, cmd.emit_digit}))
      else $error("More than one result loaded in a cycle.");

endmodule

// File: src/sicrd_datapath.sv
// Datapath of the signed integer to radix digits unit: alphabet check,
// shared restoring divider, digit buffer and output register; uses sicrd_pkg.
module sicrd_datapath #(
   parameter int MAX_RADIX  = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [VALUE_BITS-1:0]                   req_value,
   input  logic [sicrd_pkg::RADIX_W-1:0]           radix_length,
   input  sicrd_pkg::symbol_bank_type              sym_bank,
   input  sicrd_pkg::cmd_type                      cmd,
   output sicrd_pkg::status_type                   st,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [sicrd_pkg::SYMBOL_W-1:0]          rsp_symbol,
   output logic                                    rsp_alphabet_error,
   output logic                                    rsp_final_symbol
);

   localparam int DIV_STEPS = (VALUE_BITS + sicrd_pkg::DIV_BITS - 1) / sicrd_pkg::DIV_BITS;
   localparam int DIV_W     = DIV_STEPS * sicrd_pkg::DIV_BITS;
   localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
   localparam int CNT_W     = $clog2(VALUE_BITS + 1);
   localparam int ADDR_W    = $clog2(VALUE_BITS);
   localparam int RW        = sicrd_pkg::RADIX_W;
   localparam int IDX_W     = $clog2(sicrd_pkg::SYMBOL_SLOTS);

   logic                              neg_ff;
   logic [DIV_W-1:0]                  work_ff;
   logic [RW-1:0]                     rem_ff;
   logic [STEP_W-1:0]                 step_ff;
   logic [CNT_W-1:0]                  cnt_ff;
   logic [IDX_W-1:0]                  chk_ff;
   logic [sicrd_pkg::DIGIT_W-1:0]     rd_data_ff;
   logic [sicrd_pkg::DIGIT_W-1:0]     digit_mem [VALUE_BITS];

   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [sicrd_pkg::SYMBOL_W-1:0]    rsp_symbol_ff;
   logic                              rsp_error_ff;
   logic                              rsp_final_ff;

   logic [VALUE_BITS-1:0]             mag;
   logic [DIV_W-1:0]                  work_in;
   logic [RW-1:0]                     rem_in;
   logic                              step_last;
   logic [IDX_W-1:0]                  sym_addr;
   logic [sicrd_pkg::SYMBOL_W-1:0]    sym_cur;
   logic                              dup;

   assign mag = req_value[VALUE_BITS-1] ? (~req_value + VALUE_BITS'(1)) : req_value;

   always_comb begin
      logic [RW:0]                     t;
      logic [RW-1:0]                   r;
      logic [sicrd_pkg::DIV_BITS-1:0]  q;
      r = rem_ff;
      q = '0;
      for (int b = 0; b < sicrd_pkg::DIV_BITS; b++) begin
         t = {r, work_ff[DIV_W-1-b]};
         if (t >= {1'b0, radix_length}) begin
            r                               = RW'(t - {1'b0, radix_length});
            q[sicrd_pkg::DIV_BITS-1-b]      = 1'b1;
         end else begin
            r = t[RW-1:0];
         end
      end
      rem_in  = r;
      work_in = {work_ff[DIV_W-sicrd_pkg::DIV_BITS-1:0], q};
   end

   assign step_last = (step_ff == STEP_W'(DIV_STEPS - 1));
   assign sym_addr  = cmd.sel_digit ? rd_data_ff : chk_ff;
   assign sym_cur   = sym_bank[sym_addr];

   always_comb begin
      dup = 1'b0;
      for (int j = 0; j < sicrd_pkg::SYMBOL_SLOTS; j++) begin
         if ((RW'(j) > {1'b0, chk_ff}) && (RW'(j) < radix_length) &&
             (sym_bank[j] == sym_cur)) begin
            dup = 1'b1;
         end
      end
   end

   assign st.len_bad    = (radix_length < RW'(2)) ||
                          (32'(radix_length) > 32'(MAX_RADIX)) ||
                          (radix_length > RW'(sicrd_pkg::SYMBOL_SLOTS));
   assign st.sym_bad    = sicrd_pkg::symbol_forbidden(sym_cur) || dup;
   assign st.chk_last   = ({1'b0, chk_ff} == (radix_length - RW'(1)));
   assign st.div_done   = step_last &&
                          ((work_in == '0) || (cnt_ff == CNT_W'(VALUE_BITS - 1)));
   assign st.negative   = neg_ff;
   assign st.last_digit = (cnt_ff == '0);
   assign st.out_free   = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         cnt_ff  <= '0;
         chk_ff  <= '0;
      end else if (cmd.load) begin
         step_ff <= '0;
         cnt_ff  <= '0;
         chk_ff  <= '0;
      end else begin
         if (cmd.chk_next) begin
            chk_ff <= chk_ff + IDX_W'(1);
         end
         if (cmd.div_step) begin
            if (step_last) begin
               step_ff <= '0;
               cnt_ff  <= cnt_ff + CNT_W'(1);
            end else begin
               step_ff <= step_ff + STEP_W'(1);
            end
         end
         if (cmd.rd_issue) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff  <= req_value[VALUE_BITS-1];
         work_ff <= DIV_W'(mag);
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         work_ff <= work_in;
         rem_ff  <= step_last ? '0 : rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_step && step_last) begin
         digit_mem[cnt_ff[ADDR_W-1:0]] <= rem_in[sicrd_pkg::DIGIT_W-1:0];
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= digit_mem[ADDR_W'(cnt_ff - CNT_W'(1))];
      end
   end

   always_comb begin
      if (cmd.emit_err || cmd.emit_sign || cmd.emit_digit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_err) begin
         rsp_symbol_ff <= '0;
         rsp_error_ff  <= 1'b1;
         rsp_final_ff  <= 1'b1;
      end else if (cmd.emit_sign) begin
         rsp_symbol_ff <= sicrd_pkg::MINUS_SYMBOL;
         rsp_error_ff  <= 1'b0;
         rsp_final_ff  <= 1'b0;
      end else if (cmd.emit_digit) begin
         rsp_symbol_ff <= sym_cur;
         rsp_error_ff  <= 1'b0;
         rsp_final_ff  <= st.last_digit;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_symbol         = rsp_symbol_ff;
   assign rsp_alphabet_error = rsp_error_ff;
   assign rsp_final_symbol   = rsp_final_ff;

endmodule

// File: src/signed_int_to_custom_radix_digits_unit.sv
// Top level of the signed integer to radix digits unit: configuration
// registers, controller and datapath. Uses sicrd_pkg, sicrd_ctrl, sicrd_datapath.
//
// Each accepted item is a signed number; the unit returns its text in the radix
// given by the configured alphabet, one symbol per result item, a leading minus
// for negatives, the last item flagged. An invalid alphabet gives one item with
// the error flag set. One item is worked on at a time. The alphabet check goes
// through the symbols one by one (up to 32). Every digit is then found in the
// shared restoring divider, which produces four quotient bits per cycle; the
// digits are afterwards read back from the digit buffer and sent out one symbol
// at a time, after the minus sign for a negative value.
module signed_int_to_custom_radix_digits_unit #(
   parameter int MAX_RADIX  = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [VALUE_BITS-1:0]          req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sicrd_pkg::SYMBOL_W-1:0]        rsp_symbol,
   output logic                                  rsp_alphabet_error,
   output logic                                  rsp_final_symbol,
   input  logic                                  csr_write_enable,
   input  logic [sicrd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sicrd_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   logic [sicrd_pkg::RADIX_W-1:0]   radix_length_ff;
   sicrd_pkg::symbol_words_type     sym_words_ff;
   sicrd_pkg::symbol_bank_type      sym_bank;
   sicrd_pkg::cmd_type              cmd;
   sicrd_pkg::status_type           st;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_length_ff <= '0;
         sym_words_ff    <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            sicrd_pkg::CSR_RADIX_LENGTH: begin
               radix_length_ff <= csr_write_data[sicrd_pkg::RADIX_W-1:0];
            end
            sicrd_pkg::CSR_SYMBOLS_0: begin
               sym_words_ff[0] <= csr_write_data;
            end
            sicrd_pkg::CSR_SYMBOLS_1: begin
               sym_words_ff[1] <= csr_write_data;
            end
            sicrd_pkg::CSR_SYMBOLS_2: begin
               sym_words_ff[2] <= csr_write_data;
            end
            sicrd_pkg::CSR_SYMBOLS_3: begin
               sym_words_ff[3] <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign sym_bank = sicrd_pkg::symbol_bank_type'(sym_words_ff);

   sicrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   sicrd_datapath #(
      .MAX_RADIX  (MAX_RADIX),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_value          (req_value),
      .radix_length       (radix_length_ff),
      .sym_bank           (sym_bank),
      .cmd                (cmd),
      .st                 (st),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_symbol         (rsp_symbol),
      .rsp_alphabet_error (rsp_alphabet_error),
      .rsp_final_symbol   (rsp_final_symbol)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alphabet_error |-> rsp_final_symbol && (rsp_symbol == '0))
      else $error("Error item is not a single empty item.");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_alphabet_error && (rsp_symbol == sicrd_pkg::MINUS_SYMBOL)
      |-> !rsp_final_symbol)
      else $error("Minus sign flagged as the last item.");
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("New item taken while the previous one is still in work.");

endmodule
